### hdl/rotary_position_embedding_int8_table_macros.svh
// ----------------------------------------------------------------------------
// rotary position embedding assertion macros
// shared property wrappers for the checker
// ----------------------------------------------------------------------------
`ifndef ROTARY_POSITION_EMBEDDING_INT8_TABLE_MACROS_SVH
`define ROTARY_POSITION_EMBEDDING_INT8_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define RPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define RPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/rpe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpe_pkg
// types and constants for the rotary position embedding block
// ----------------------------------------------------------------------------
package rpe_pkg;

  localparam int MAX_POSITIONS = 4096;
  localparam int TABLE_COLUMNS = 128;
  localparam int VALUE_BITS    = 16;
  localparam int CODE_BITS     = 8;

  localparam int POS_BITS    = $clog2(MAX_POSITIONS);
  localparam int COL_BITS    = $clog2(TABLE_COLUMNS);
  localparam int LIMIT_BITS  = POS_BITS + 1;
  localparam int TABLE_AW    = POS_BITS + COL_BITS;
  localparam int TABLE_DEPTH = MAX_POSITIONS * TABLE_COLUMNS;
  localparam int ENTRY_BITS  = 2 * CODE_BITS;

  // products and their sums
  localparam int PROD_BITS = VALUE_BITS + CODE_BITS;
  localparam int SUM_BITS  = PROD_BITS + 1;

  // divide by 127 as multiply by ceil(2^31/127) and shift by 31,
  // exact for every dividend below 2^31/119
  localparam int RECIP_SHIFT = 31;
  localparam int RECIP_BITS  = 25;
  localparam logic [RECIP_BITS-1:0] RECIP_MUL = RECIP_BITS'(16909321);
  localparam int MUL_BITS  = SUM_BITS + RECIP_BITS;
  localparam int QUOT_BITS = MUL_BITS - RECIP_SHIFT;
  localparam logic [SUM_BITS-1:0] ROUND_HALF = SUM_BITS'(63);

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(4096);
  localparam logic [LIMIT_BITS-1:0] LIMIT_MAX   = LIMIT_BITS'(MAX_POSITIONS);
  localparam logic [LIMIT_BITS-1:0] LIMIT_MIN   = LIMIT_BITS'(1);
  localparam logic [COL_BITS:0]     COL_LIMIT   = (COL_BITS + 1)'(TABLE_COLUMNS);

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_ROTATE  = 2'd1,
    OP_ADVANCE = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    op_e                           op;
    logic [POS_BITS-1:0]           row;
    logic [COL_BITS-1:0]           column;
    logic signed [VALUE_BITS-1:0]  first_value;
    logic signed [VALUE_BITS-1:0]  second_value;
    logic signed [CODE_BITS-1:0]   sine_code;
    logic signed [CODE_BITS-1:0]   cosine_code;
    logic [LIMIT_BITS-1:0]         advance_count;
  } in_item_t;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] first_rotated;
    logic signed [VALUE_BITS-1:0] second_rotated;
    status_e                      status;
    logic [POS_BITS-1:0]          current_base;
  } out_item_t;

  // per-stage control that rides along with the datapath
  typedef struct packed {
    logic                rot;
    status_e             status;
    logic [POS_BITS-1:0] base;
  } stage_ctl_t;

  localparam logic [QUOT_BITS-1:0] POS_MAX = QUOT_BITS'((1 << (VALUE_BITS - 1)) - 1);
  localparam logic [QUOT_BITS-1:0] NEG_MAX = QUOT_BITS'(1 << (VALUE_BITS - 1));

  // apply sign to a rounded magnitude and clamp, msb is the saturate flag
  function automatic logic [VALUE_BITS:0] clamp_value(input logic neg,
                                                     input logic [QUOT_BITS-1:0] q);
    logic [QUOT_BITS-1:0] neg_q;
    neg_q = -q;
    if (!neg && q > POS_MAX) begin
      return {1'b1, POS_MAX[VALUE_BITS-1:0]};
    end else if (neg && q > NEG_MAX) begin
      return {1'b1, NEG_MAX[VALUE_BITS-1:0]};
    end else if (neg) begin
      return {1'b0, neg_q[VALUE_BITS-1:0]};
    end else begin
      return {1'b0, q[VALUE_BITS-1:0]};
    end
  endfunction

endpackage

### hdl/rotary_position_embedding_int8_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotary_position_embedding_int8_table
// int8 sine/cosine table with base position, rotates one value pair per item
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | input     | in_valid_i/in_ready_o   | rpe_pkg::in_item_t
//  out     | output    | out_valid_o/out_ready_i | rpe_pkg::out_item_t
//  cfg     | input     | cfg_valid_i/cfg_ready_o | position_limit, 13 bits
//
//  one item per cycle while the output is not stalled; the result passes the
//  stages (table read, multiply, magnitude, divide, clamp), the last being the
//  output register, where it can be taken
//  the table does at most one access per item: a load writes at accept,
//  a rotate reads at accept, so a load is visible to any later rotate
//  reset clears the base, the limit (to 4096) and all stage valids; the
//  table itself is not cleared
//  a stalled output register freezes every stage and drops in_ready_o
// ----------------------------------------------------------------------------
module rotary_position_embedding_int8_table (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rpe_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rpe_pkg::out_item_t out_item_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [rpe_pkg::LIMIT_BITS-1:0] cfg_data_i
);

  // --------------------------------------------------------------------------
  // configuration and base position
  // --------------------------------------------------------------------------
  logic [rpe_pkg::LIMIT_BITS-1:0] limit_q;
  logic [rpe_pkg::LIMIT_BITS-1:0] limit_eff;
  logic [rpe_pkg::POS_BITS-1:0]   base_q, base_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= rpe_pkg::LIMIT_RESET;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // zero acts as one, anything above the table height acts as the height
  always_comb begin
    if (limit_q == '0) begin
      limit_eff = rpe_pkg::LIMIT_MIN;
    end else if (limit_q > rpe_pkg::LIMIT_MAX) begin
      limit_eff = rpe_pkg::LIMIT_MAX;
    end else begin
      limit_eff = limit_q;
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: every stage moves when the output register can
  // --------------------------------------------------------------------------
  logic advance;
  logic accept;
  logic v1_q, v2_q, v3_q, v4_q, vo_q;

  assign advance    = !vo_q || out_ready_i;
  assign in_ready_o = advance;
  assign accept     = in_valid_i && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q   <= 1'b0;
      v2_q   <= 1'b0;
      v3_q   <= 1'b0;
      v4_q   <= 1'b0;
      vo_q   <= 1'b0;
      base_q <= '0;
    end else if (advance) begin
      v1_q <= accept;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      vo_q <= v4_q;
      if (accept) begin
        base_q <= base_d;
      end
    end
  end

  // --------------------------------------------------------------------------
  // decode at accept: range checks, table address, base update
  // --------------------------------------------------------------------------
  logic [rpe_pkg::LIMIT_BITS-1:0] pos;
  logic [rpe_pkg::LIMIT_BITS:0]   adv_sum;
  logic                           col_ok, load_ok, rot_ok;
  rpe_pkg::stage_ctl_t            ctl0;

  assign pos     = {1'b0, base_q} + {1'b0, in_item_i.row};
  assign adv_sum = {2'b00, base_q} + {1'b0, in_item_i.advance_count};
  assign col_ok  = {1'b0, in_item_i.column} < rpe_pkg::COL_LIMIT;
  assign load_ok = ({1'b0, in_item_i.row} < limit_eff) && col_ok;
  // position beyond the limit is checked without wrap
  assign rot_ok  = (pos < limit_eff) && col_ok;

  always_comb begin
    base_d      = base_q;
    ctl0.rot    = 1'b0;
    ctl0.status = rpe_pkg::ST_OK;
    case (in_item_i.op)
      rpe_pkg::OP_LOAD: begin
        ctl0.status = load_ok ? rpe_pkg::ST_OK : rpe_pkg::ST_RANGE;
      end
      rpe_pkg::OP_ROTATE: begin
        ctl0.rot    = rot_ok;
        ctl0.status = rot_ok ? rpe_pkg::ST_OK : rpe_pkg::ST_RANGE;
      end
      rpe_pkg::OP_ADVANCE: begin
        // wrap to zero once the limit is reached
        if (adv_sum >= {1'b0, limit_eff}) begin
          base_d = '0;
        end else begin
          base_d = adv_sum[rpe_pkg::POS_BITS-1:0];
        end
      end
      rpe_pkg::OP_CLEAR: begin
        base_d = '0;
      end
      default: begin
        base_d = base_q;
      end
    endcase
    ctl0.base = base_d;
  end

  // --------------------------------------------------------------------------
  // angle table: sine code in the high byte, cosine in the low byte
  // --------------------------------------------------------------------------
  logic [rpe_pkg::ENTRY_BITS-1:0] tbl_mem [rpe_pkg::TABLE_DEPTH];
  logic [rpe_pkg::ENTRY_BITS-1:0] tbl_rdata_q;
  logic                           tbl_wr, tbl_rd;
  logic [rpe_pkg::TABLE_AW-1:0]   tbl_waddr, tbl_raddr;

  assign tbl_wr    = accept && (in_item_i.op == rpe_pkg::OP_LOAD) && load_ok;
  assign tbl_rd    = accept && (in_item_i.op == rpe_pkg::OP_ROTATE) && rot_ok;
  assign tbl_waddr = {in_item_i.row, in_item_i.column};
  assign tbl_raddr = {pos[rpe_pkg::POS_BITS-1:0], in_item_i.column};

  always_ff @(posedge clk_i) begin
    if (tbl_wr) begin
      tbl_mem[tbl_waddr] <= {in_item_i.sine_code, in_item_i.cosine_code};
    end
    if (tbl_rd) begin
      tbl_rdata_q <= tbl_mem[tbl_raddr];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: operands wait for the table word
  // --------------------------------------------------------------------------
  rpe_pkg::stage_ctl_t                   ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic signed [rpe_pkg::VALUE_BITS-1:0] a1_q, b1_q;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl1_q <= ctl0;
      a1_q   <= in_item_i.first_value;
      b1_q   <= in_item_i.second_value;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: four independent products
  // --------------------------------------------------------------------------
  logic signed [rpe_pkg::CODE_BITS-1:0]  sin1, cos1;
  logic signed [rpe_pkg::PROD_BITS-1:0]  p_ac_q, p_bs_q, p_as_q, p_bc_q;

  assign sin1 = tbl_rdata_q[rpe_pkg::ENTRY_BITS-1:rpe_pkg::CODE_BITS];
  assign cos1 = tbl_rdata_q[rpe_pkg::CODE_BITS-1:0];

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl2_q <= ctl1_q;
      p_ac_q <= a1_q * cos1;
      p_bs_q <= b1_q * sin1;
      p_as_q <= a1_q * sin1;
      p_bc_q <= b1_q * cos1;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: combine, take magnitude, add the rounding half
  // --------------------------------------------------------------------------
  logic signed [rpe_pkg::SUM_BITS-1:0] n1, n2;
  logic [rpe_pkg::SUM_BITS-1:0]        mag1, mag2;
  logic [rpe_pkg::SUM_BITS-1:0]        m1_q, m2_q;
  logic                                neg1_q, neg2_q;

  assign n1   = rpe_pkg::SUM_BITS'(p_ac_q) - rpe_pkg::SUM_BITS'(p_bs_q);
  assign n2   = rpe_pkg::SUM_BITS'(p_as_q) + rpe_pkg::SUM_BITS'(p_bc_q);
  assign mag1 = n1[rpe_pkg::SUM_BITS-1] ? -n1 : n1;
  assign mag2 = n2[rpe_pkg::SUM_BITS-1] ? -n2 : n2;

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl3_q <= ctl2_q;
      m1_q   <= mag1 + rpe_pkg::ROUND_HALF;
      m2_q   <= mag2 + rpe_pkg::ROUND_HALF;
      neg1_q <= n1[rpe_pkg::SUM_BITS-1];
      neg2_q <= n2[rpe_pkg::SUM_BITS-1];
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: divide by 127 through the reciprocal
  // --------------------------------------------------------------------------
  logic [rpe_pkg::MUL_BITS-1:0]  prod1, prod2;
  logic [rpe_pkg::QUOT_BITS-1:0] q1_q, q2_q;
  logic                          neg1_4_q, neg2_4_q;

  assign prod1 = {{rpe_pkg::RECIP_BITS{1'b0}}, m1_q} * rpe_pkg::MUL_BITS'(rpe_pkg::RECIP_MUL);
  assign prod2 = {{rpe_pkg::RECIP_BITS{1'b0}}, m2_q} * rpe_pkg::MUL_BITS'(rpe_pkg::RECIP_MUL);

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl4_q   <= ctl3_q;
      q1_q     <= prod1[rpe_pkg::MUL_BITS-1:rpe_pkg::RECIP_SHIFT];
      q2_q     <= prod2[rpe_pkg::MUL_BITS-1:rpe_pkg::RECIP_SHIFT];
      neg1_4_q <= neg1_q;
      neg2_4_q <= neg2_q;
    end
  end

  // --------------------------------------------------------------------------
  // output register: sign, clamp, status
  // --------------------------------------------------------------------------
  logic [rpe_pkg::VALUE_BITS:0] c1, c2;
  rpe_pkg::out_item_t           res_d, res_q;

  assign c1 = rpe_pkg::clamp_value(neg1_4_q, q1_q);
  assign c2 = rpe_pkg::clamp_value(neg2_4_q, q2_q);

  always_comb begin
    res_d.current_base = ctl4_q.base;
    if (ctl4_q.rot) begin
      res_d.first_rotated  = c1[rpe_pkg::VALUE_BITS-1:0];
      res_d.second_rotated = c2[rpe_pkg::VALUE_BITS-1:0];
      res_d.status = (c1[rpe_pkg::VALUE_BITS] || c2[rpe_pkg::VALUE_BITS]) ?
                     rpe_pkg::ST_SAT : rpe_pkg::ST_OK;
    end else begin
      // loads, base ops and rejected rotates give zero values
      res_d.first_rotated  = '0;
      res_d.second_rotated = '0;
      res_d.status         = ctl4_q.status;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = vo_q;
  assign out_item_o  = res_q;

endmodule

### hdl/rpe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpe_checker
// port-level checks for the rotary position embedding block
// ----------------------------------------------------------------------------
`include "rotary_position_embedding_int8_table_macros.svh"

module rpe_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rpe_pkg::out_item_t out_item_o
);

  // a waiting result holds still
  `RPE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_item_o), "result changed while stalled")

  // an empty output register never blocks the input
  `RPE_ASSERT_NOW(a_ready_when_empty, clk_i, rst_ni, !out_valid_o, in_ready_o, "input stalled with empty output")

  // out-of-range items carry zero values
  `RPE_ASSERT_NOW(a_range_zero, clk_i, rst_ni, out_valid_o && out_item_o.status == rpe_pkg::ST_RANGE, out_item_o.first_rotated == '0 && out_item_o.second_rotated == '0, "range error with nonzero values")

  // a saturated item has a value at a rail
  `RPE_ASSERT_NOW(a_sat_rail, clk_i, rst_ni, out_valid_o && out_item_o.status == rpe_pkg::ST_SAT, out_item_o.first_rotated == 16'sh7fff || out_item_o.first_rotated == 16'sh8000 || out_item_o.second_rotated == 16'sh7fff || out_item_o.second_rotated == 16'sh8000, "saturation flag without clamped value")

endmodule

bind rotary_position_embedding_int8_table rpe_checker u_rpe_checker (.*);
